// ===== rtl/tccw_pkg.sv =====
// Shared types and constants for the text console cursor writer.
// Depends on nothing; every other file in rtl/ imports it.
package tccw_pkg;

    // Command codes on the input item
    localparam logic [2:0] CMD_PUT        = 3'd0;
    localparam logic [2:0] CMD_NEWLINE    = 3'd1;
    localparam logic [2:0] CMD_DEL_BEHIND = 3'd2;
    localparam logic [2:0] CMD_DEL_AHEAD  = 3'd3;
    localparam logic [2:0] CMD_SET        = 3'd4;

    localparam logic       KIND_CELL  = 1'b0;
    localparam logic       KIND_PORT  = 1'b1;
    localparam logic       PORT_INDEX = 1'b0;
    localparam logic       PORT_DATA  = 1'b1;

    // CRTC cursor location registers
    localparam logic [7:0] CRTC_IDX_POS_LO = 8'h0F;
    localparam logic [7:0] CRTC_IDX_POS_HI = 8'h0E;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] ATTR_RESET = 8'h0F;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] char_code;
        logic [6:0] col;
        logic [4:0] row;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [10:0] cell_addr;
        logic [15:0] cell_value;
        logic        io_port;
        logic [7:0]  io_data;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_DEL_BEHIND,
        OP_DEL_AHEAD,
        OP_SET
    } op_t;

    // One classified command waiting for the sequencer
    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
        logic [6:0] col;
        logic [4:0] row;
    } op_entry_t;

    // Steps of a command: one cell write, or a cursor move of four port writes
    typedef enum logic [2:0] {
        TK_CELL,
        TK_STAY,
        TK_LEFT,
        TK_RIGHT,
        TK_NEWLINE,
        TK_SET
    } tok_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } bk_state_t;

    function automatic tok_t seq_token(op_t op, logic [1:0] step);
        tok_t t;
        t = TK_STAY;
        unique case (op)
            OP_PUT:     t = (step == 2'd0) ? TK_CELL : TK_STAY;
            OP_NEWLINE: t = TK_NEWLINE;
            OP_DEL_BEHIND, OP_DEL_AHEAD:
            begin
                unique case (step)
                    2'd1:    t = TK_CELL;
                    2'd2:    t = TK_STAY;
                    default: t = (op == OP_DEL_BEHIND) ? TK_LEFT : TK_RIGHT;
                endcase
            end
            OP_SET:     t = TK_SET;
            default:    t = TK_STAY;
        endcase
        return t;
    endfunction

    // Index of the final step of each command
    function automatic logic [1:0] seq_last(op_t op);
        logic [1:0] n;
        n = 2'd0;
        unique case (op)
            OP_PUT:                      n = 2'd1;
            OP_DEL_BEHIND, OP_DEL_AHEAD: n = 2'd3;
            default:                     n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/tccw_front.sv =====
// Front end: classifies input commands and saturates set-cursor targets.
// Depends on tccw_pkg; feeds tccw_opq.
module tccw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 push,
    output logic                 full,
    input  tccw_pkg::in_item_t   item,
    output logic                 q_push,
    output tccw_pkg::op_entry_t  q_entry,
    input  logic                 q_full
);
    import tccw_pkg::*;

    logic known;

    always_comb
    begin
        known         = 1'b1;
        q_entry.op    = OP_PUT;
        q_entry.ch    = item.char_code;
        q_entry.col   = item.col;
        q_entry.row   = item.row;
        unique case (item.cmd)
            CMD_PUT:        q_entry.op = OP_PUT;
            CMD_NEWLINE:    q_entry.op = OP_NEWLINE;
            CMD_DEL_BEHIND:
            begin
                q_entry.op = OP_DEL_BEHIND;
                q_entry.ch = SPACE_CHAR;
            end
            CMD_DEL_AHEAD:
            begin
                q_entry.op = OP_DEL_AHEAD;
                q_entry.ch = SPACE_CHAR;
            end
            CMD_SET:
            begin
                q_entry.op = OP_SET;
                // clamp the target to the grid
                if (9'(item.col) > 9'(COLUMNS - 1))
                    q_entry.col = 7'(COLUMNS - 1);
                if (7'(item.row) > 7'(ROWS - 1))
                    q_entry.row = 5'(ROWS - 1);
            end
            default:        known = 1'b0;
        endcase
    end

    // Unused command codes are taken and dropped here
    assign full   = q_full;
    assign q_push = push && !q_full && known;

endmodule

// ===== rtl/tccw_opq.sv =====
// Short command queue between the front end and the sequencer.
// Depends on tccw_pkg for the entry type.
module tccw_opq #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tccw_pkg::op_entry_t  wr_entry,
    output logic                 full,
    input  logic                 pop,
    output tccw_pkg::op_entry_t  rd_entry,
    output logic                 valid
);
    import tccw_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    op_entry_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full     = (count_reg == NW'(DEPTH));
    assign valid    = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + NW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

// ===== rtl/tccw_back.sv =====
// Back end: steps through each command, tracks the cursor and emits one cell or port
// write per cycle while the output register is free or popped. Depends on tccw_pkg.
module tccw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 opq_valid,
    input  tccw_pkg::op_entry_t  opq_entry,
    output logic                 opq_pop,
    input  logic [7:0]           attr,
    output logic                 empty,
    input  logic                 pop,
    output tccw_pkg::out_item_t  result
);
    import tccw_pkg::*;

    // The column can run one past the grid after a delete ahead from three short of
    // the edge, and to minus one after a delete behind that wraps; keep a sign bit.
    localparam int CW = $clog2(COLUMNS + 1) + 1;
    localparam int RW = $clog2(ROWS);

    bk_state_t     state_reg, state_next;
    op_entry_t     op_reg, op_next;
    logic [1:0]    step_reg, step_next;
    logic [1:0]    byte_reg, byte_next;
    logic          rep_reg, rep_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          res_valid_reg, res_valid_next;
    out_item_t     res_reg, res_next;

    tok_t          tok;
    logic          is_move;
    logic          emit_ready;
    logic          fire;
    logic          drop;
    logic          last_res;
    logic [CW-1:0] col_inc;
    logic          wrap;
    logic [RW-1:0] row_up;
    logic [CW-1:0] tgt_col;
    logic [RW-1:0] tgt_row;
    logic [15:0]   col_sx;
    logic [15:0]   tgt_sx;
    logic [15:0]   pos;
    out_item_t     res_build;

    assign tok        = seq_token(op_reg.op, step_reg);
    assign is_move    = (tok != TK_CELL);
    assign emit_ready = !res_valid_reg || pop;
    assign col_sx     = {{(16 - CW){col_reg[CW-1]}}, col_reg};
    assign tgt_sx     = {{(16 - CW){tgt_col[CW-1]}}, tgt_col};
    assign pos        = 16'(row_reg) * 16'(COLUMNS) + col_sx;
    assign col_inc    = col_reg + CW'(1);
    assign wrap       = (col_inc >= CW'(COLUMNS));
    assign row_up     = (row_reg == RW'(ROWS - 1)) ? row_reg : row_reg + RW'(1);

    // Deletes at the edge of the line do nothing
    assign drop = (opq_entry.op == OP_DEL_BEHIND && col_reg == '0)
               || (opq_entry.op == OP_DEL_AHEAD && col_reg >= CW'(COLUMNS - 1));

    // A move repeats once when the cell write wrapped the line
    assign last_res = is_move && byte_reg == 2'd3 && !(tok == TK_STAY && rep_reg)
                   && step_reg == seq_last(op_reg.op);

    always_comb
    begin
        tgt_col = col_reg;
        tgt_row = row_reg;
        case (tok)
            TK_LEFT:    tgt_col = col_reg - CW'(1);
            TK_RIGHT:   tgt_col = col_reg + CW'(1);
            TK_NEWLINE:
            begin
                tgt_col = '0;
                tgt_row = row_up;
            end
            TK_SET:
            begin
                tgt_col = CW'(op_reg.col);
                tgt_row = RW'(op_reg.row);
            end
            default:    tgt_col = col_reg;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (opq_valid && !drop) state_next = BK_RUN;
            BK_RUN:  if (fire && last_res) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // Outputs of the state machine
    always_comb
    begin
        opq_pop = 1'b0;
        fire    = 1'b0;
        unique case (state_reg)
            BK_IDLE: opq_pop = opq_valid;
            BK_RUN:  fire    = emit_ready;
            default: fire    = 1'b0;
        endcase
    end

    always_comb
    begin
        res_build            = '0;
        res_build.cursor_col = col_sx[6:0];
        res_build.cursor_row = 5'(row_reg);
        if (!is_move)
        begin
            res_build.kind       = KIND_CELL;
            res_build.cell_addr  = pos[10:0];
            res_build.cell_value = {attr, op_reg.ch};
        end
        else
        begin
            res_build.kind    = KIND_PORT;
            res_build.io_port = byte_reg[0] ? PORT_DATA : PORT_INDEX;
            case (byte_reg)
                2'd0:
                begin
                    res_build.io_data    = CRTC_IDX_POS_LO;
                    res_build.cursor_col = tgt_sx[6:0];
                    res_build.cursor_row = 5'(tgt_row);
                end
                2'd1:    res_build.io_data = pos[7:0];
                2'd2:    res_build.io_data = CRTC_IDX_POS_HI;
                default: res_build.io_data = pos[15:8];
            endcase
            res_build.last = last_res;
        end
    end

    always_comb
    begin
        op_next        = op_reg;
        step_next      = step_reg;
        byte_next      = byte_reg;
        rep_next       = rep_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        if (state_reg == BK_IDLE && opq_valid)
        begin
            op_next   = opq_entry;
            step_next = 2'd0;
            byte_next = 2'd0;
            rep_next  = 1'b0;
        end

        if (fire)
        begin
            if (!is_move)
            begin
                // advance past the written cell, wrapping to a new line
                step_next = step_reg + 2'd1;
                if (wrap)
                begin
                    col_next = '0;
                    row_next = row_up;
                    rep_next = 1'b1;
                end
                else
                    col_next = col_inc;
            end
            else
            begin
                if (byte_reg == 2'd0)
                begin
                    col_next = tgt_col;
                    row_next = tgt_row;
                end
                if (byte_reg == 2'd3)
                begin
                    byte_next = 2'd0;
                    if (tok == TK_STAY && rep_reg)
                        rep_next = 1'b0;
                    else
                        step_next = step_reg + 2'd1;
                end
                else
                    byte_next = byte_reg + 2'd1;
            end
            res_valid_next = 1'b1;
            res_next       = res_build;
        end
        else if (pop)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= 2'd0;
            byte_reg      <= 2'd0;
            rep_reg       <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            byte_reg      <= byte_next;
            rep_reg       <= rep_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        res_reg <= res_next;
    end

    assign empty  = !res_valid_reg;
    assign result = res_reg;

`ifndef SYNTHESIS
    a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= RW'(ROWS - 1))
        && ((col_reg <= CW'(COLUMNS)) || (col_reg >= {{(CW - 1){1'b1}}, 1'b0})))
        else $error("cursor outside its reachable range");

    a_byte_only_in_move: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_RUN && byte_reg != 2'd0) |-> is_move)
        else $error("port byte counter advanced during a cell write");

    a_rep_after_cell: assert property (@(posedge clk) disable iff (!rst_n)
        rep_reg |-> (state_reg == BK_RUN && tok == TK_STAY))
        else $error("line wrap pending outside the move after a cell write");

    a_last_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_res) |=> (state_reg == BK_IDLE && byte_reg == 2'd0))
        else $error("sequencer kept running after the final write");
`endif

endmodule

// ===== rtl/text_console_cursor_writer.sv =====
// Text console cursor writer: an accepted command goes through the command queue to the
// sequencer, then one cell or port write per cycle while pop is held (none to 17 per command).
// The sequencer takes each command off its queue in an idle state of its own before its
// writes begin; input transfers continue while the queue has room.
// Reset clears the cursor to column 0 row 0, the attribute to 0x0F, the queue and the output.
module text_console_cursor_writer #(
    parameter int COLUMNS     = 80,
    parameter int ROWS        = 25,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  tccw_pkg::in_item_t   item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data,
    output logic                 empty,
    input  logic                 pop,
    output tccw_pkg::out_item_t  result
);
    import tccw_pkg::*;

    logic [7:0] attr_byte_reg;
    logic       q_push;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    op_entry_t  q_wr_entry;
    op_entry_t  q_rd_entry;

    assign cfg_ready = 1'b1;

    // hold the attribute until the next configuration transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            attr_byte_reg <= ATTR_RESET;
        else if (cfg_valid && cfg_ready)
            attr_byte_reg <= cfg_data;
    end

    tccw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .push    (push),
        .full    (full),
        .item    (item),
        .q_push  (q_push),
        .q_entry (q_wr_entry),
        .q_full  (q_full)
    );

    tccw_opq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_opq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .rd_entry (q_rd_entry),
        .valid    (q_valid)
    );

    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .opq_valid (q_valid),
        .opq_entry (q_rd_entry),
        .opq_pop   (q_pop),
        .attr      (attr_byte_reg),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== tb/sv/text_console_cursor_writer_tb.sv =====
// Self-checking testbench for text_console_cursor_writer: directed and random console commands,
// checked write by write against a cursor and attribute model kept in the testbench.
// Depends on tccw_pkg and the text_console_cursor_writer RTL only.
module text_console_cursor_writer_tb;
    import tccw_pkg::*;

    localparam int COLS          = 80;
    localparam int LINES         = 25;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 200;
    localparam int CYCLE_LIMIT   = 500000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    in_item_t    item      = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;
    logic        empty;
    logic        pop       = 1'b0;
    out_item_t   result;

    in_item_t    cmd_backlog[$];
    out_item_t   due_writes[$];

    // Console model: cursor and attribute as the block should hold them
    int unsigned cur_col   = 0;
    int unsigned cur_row   = 0;
    logic [7:0]  attr_byte = ATTR_RESET;

    int          send_idle_pct = 31;
    int          recv_idle_pct = 88;
    int          hold_asks     = 0;
    int          hold_given    = 0;
    int          hold_left     = 0;
    int          errors        = 0;
    int          cycle_count   = 0;

    text_console_cursor_writer #(
        .COLUMNS (COLS),
        .ROWS    (LINES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic emit_write(logic k, int addr, logic [15:0] val, logic p, logic [7:0] d);
        out_item_t w;
        w            = '0;
        w.kind       = k;
        w.cell_addr  = addr[10:0];
        w.cell_value = val;
        w.io_port    = p;
        w.io_data    = d;
        w.cursor_col = cur_col[6:0];
        w.cursor_row = cur_row[4:0];
        w.last       = 1'b0;
        due_writes.push_back(w);
    endtask

    // Four CRTC port writes: low index, low byte, high index, high byte
    task automatic move_to(int unsigned x, int unsigned y);
        int unsigned pos;
        cur_col = x;
        cur_row = y;
        pos     = y * COLS + x;
        emit_write(KIND_PORT, 0, '0, PORT_INDEX, CRTC_IDX_POS_LO);
        emit_write(KIND_PORT, 0, '0, PORT_DATA, pos[7:0]);
        emit_write(KIND_PORT, 0, '0, PORT_INDEX, CRTC_IDX_POS_HI);
        emit_write(KIND_PORT, 0, '0, PORT_DATA, pos[15:8]);
    endtask

    task automatic line_feed();
        cur_col = 0;
        cur_row = cur_row + 1;
        if (cur_row >= LINES)
            cur_row = LINES - 1;
        move_to(cur_col, cur_row);
    endtask

    task automatic put_glyph(logic [7:0] c);
        emit_write(KIND_CELL, cur_row * COLS + cur_col, {attr_byte, c}, PORT_INDEX, '0);
        cur_col = cur_col + 1;
        if (cur_col >= COLS)
            line_feed();
        move_to(cur_col, cur_row);
    endtask

    task automatic console_step(in_item_t it);
        int        n0;
        int        x;
        int        y;
        out_item_t w;
        n0 = due_writes.size();
        case (it.cmd)
            CMD_PUT:
                put_glyph(it.char_code);
            CMD_NEWLINE:
                line_feed();
            CMD_DEL_BEHIND:
                if (cur_col != 0)
                begin
                    move_to(cur_col - 1, cur_row);
                    put_glyph(SPACE_CHAR);
                    move_to(cur_col - 1, cur_row);
                end
            CMD_DEL_AHEAD:
                if (cur_col < COLS - 1)
                begin
                    move_to(cur_col + 1, cur_row);
                    put_glyph(SPACE_CHAR);
                    move_to(cur_col + 1, cur_row);
                end
            CMD_SET:
            begin
                x = int'(it.col);
                y = int'(it.row);
                if (x > COLS - 1)
                    x = COLS - 1;
                if (y > LINES - 1)
                    y = LINES - 1;
                move_to(x, y);
            end
            default:
                ;
        endcase
        // Mark the final write of this command
        if (due_writes.size() > n0)
        begin
            w      = due_writes.pop_back();
            w.last = 1'b1;
            due_writes.push_back(w);
        end
    endtask

    // Sender: offer items from the backlog, hold an offer while the block is full
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                console_step(item);
                void'(cmd_backlog.pop_front());
            end
            if (!(push && full))
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    push <= 1'b1;
                    item <= cmd_backlog[0];
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Receiver: check each transfer against the oldest write due
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (due_writes.size() == 0)
                begin
                    errors++;
                    if (errors < 30)
                        $display("%0t: unexpected write: got kind=%0d addr=%0d value=%h ",
                                 $time, result.kind, result.cell_addr, result.cell_value,
                                 "port=%0d data=%h col=%0d row=%0d last=%0d",
                                 result.io_port, result.io_data, result.cursor_col,
                                 result.cursor_row, result.last);
                end
                else
                begin
                    out_item_t want;
                    want = due_writes.pop_front();
                    if (result.kind !== want.kind || result.cell_addr !== want.cell_addr ||
                        result.cell_value !== want.cell_value ||
                        result.io_port !== want.io_port || result.io_data !== want.io_data ||
                        result.cursor_col !== want.cursor_col ||
                        result.cursor_row !== want.cursor_row || result.last !== want.last)
                    begin
                        errors++;
                        if (errors < 30)
                            $display("%0t: write mismatch: expected kind=%0d addr=%0d ",
                                     $time, want.kind, want.cell_addr,
                                     "value=%h port=%0d data=%h col=%0d row=%0d last=%0d",
                                     want.cell_value, want.io_port, want.io_data,
                                     want.cursor_col, want.cursor_row, want.last,
                                     ", got kind=%0d addr=%0d value=%h port=%0d data=%h ",
                                     result.kind, result.cell_addr, result.cell_value,
                                     result.io_port, result.io_data,
                                     "col=%0d row=%0d last=%0d",
                                     result.cursor_col, result.cursor_row, result.last);
                    end
                end
            end
            if (hold_given != hold_asks)
            begin
                hold_given = hold_asks;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic add_cmd(logic [2:0] c, logic [7:0] ch, logic [6:0] x, logic [4:0] y);
        in_item_t it;
        it.cmd       = c;
        it.char_code = ch;
        it.col       = x;
        it.row       = y;
        cmd_backlog.push_back(it);
    endtask

    // Random commands, biased towards the right edge and the bottom row
    task automatic add_random(int n);
        int         counted;
        int         r;
        logic [2:0] c;
        logic [6:0] x;
        logic [4:0] y;
        counted = 0;
        while (counted < n)
        begin
            r = $urandom_range(99);
            x = 7'($urandom_range(127));
            y = 5'($urandom_range(31));
            if (r < 40)
                c = CMD_PUT;
            else if (r < 50)
                c = CMD_NEWLINE;
            else if (r < 62)
                c = CMD_DEL_BEHIND;
            else if (r < 74)
                c = CMD_DEL_AHEAD;
            else if (r < 92)
            begin
                c = CMD_SET;
                r = $urandom_range(99);
                if (r < 30)
                    x = 7'($urandom_range(COLS - 1, COLS - 4));
                else if (r < 45)
                    x = 7'($urandom_range(127, COLS));
                r = $urandom_range(99);
                if (r < 20)
                    y = 5'($urandom_range(31, LINES));
                else if (r < 40)
                    y = 5'(LINES - 1);
            end
            else
                c = 3'($urandom_range(7, 5));
            add_cmd(c, 8'($urandom_range(255)), x, y);
            if (c <= CMD_SET)
                counted++;
        end
    endtask

    // Wait until every command is taken and every write has arrived, then let the block go idle
    task automatic settle();
        while (cmd_backlog.size() != 0 || push || due_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_attr(logic [7:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        attr_byte = v;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, wraps, clamps and commands that do nothing
        add_cmd(CMD_PUT, 8'h00, 7'd0, 5'd0);
        add_cmd(CMD_PUT, 8'hFF, 7'd127, 5'd31);
        add_cmd(CMD_PUT, 8'h80, 7'd0, 5'd0);
        add_cmd(CMD_DEL_BEHIND, 8'h00, 7'd0, 5'd0);
        add_cmd(CMD_SET, 8'h00, 7'd0, 5'd7);
        add_cmd(CMD_DEL_BEHIND, 8'hFF, 7'd127, 5'd31);
        add_cmd(CMD_SET, 8'h00, 7'd127, 5'd31);
        add_cmd(CMD_PUT, 8'h41, 7'd0, 5'd0);
        add_cmd(CMD_NEWLINE, 8'h00, 7'd0, 5'd0);
        add_cmd(CMD_SET, 8'h00, 7'd79, 5'd3);
        add_cmd(CMD_DEL_AHEAD, 8'h00, 7'd0, 5'd0);
        add_cmd(CMD_PUT, 8'h7E, 7'd0, 5'd0);
        add_cmd(CMD_SET, 8'h00, 7'd78, 5'd3);
        add_cmd(CMD_DEL_AHEAD, 8'h00, 7'd0, 5'd0);
        add_cmd(CMD_SET, 8'h00, 7'd78, 5'd24);
        add_cmd(CMD_DEL_AHEAD, 8'h00, 7'd0, 5'd0);
        add_cmd(CMD_DEL_AHEAD, 8'h00, 7'd0, 5'd0);
        add_cmd(CMD_SET, 8'h00, 7'd80, 5'd25);
        add_cmd(CMD_DEL_BEHIND, 8'h00, 7'd0, 5'd0);
        add_cmd(CMD_SET, 8'h00, 7'd0, 5'd0);
        add_cmd(3'd5, 8'hAA, 7'd85, 5'd10);
        add_cmd(3'd6, 8'h55, 7'd42, 5'd21);
        add_cmd(3'd7, 8'hFF, 7'd127, 5'd31);
        add_cmd(CMD_NEWLINE, 8'h00, 7'd0, 5'd0);
        add_cmd(CMD_PUT, 8'h20, 7'd0, 5'd0);
        // Cursor pushed one past the line end, then below column zero
        add_cmd(CMD_SET, 8'h00, 7'd77, 5'd5);
        add_cmd(CMD_DEL_AHEAD, 8'h00, 7'd0, 5'd0);
        add_cmd(CMD_PUT, 8'h42, 7'd0, 5'd0);
        add_cmd(CMD_SET, 8'h00, 7'd77, 5'd0);
        add_cmd(CMD_DEL_AHEAD, 8'h00, 7'd0, 5'd0);
        add_cmd(CMD_DEL_AHEAD, 8'h00, 7'd0, 5'd0);
        add_cmd(CMD_DEL_BEHIND, 8'h00, 7'd0, 5'd0);
        add_cmd(CMD_DEL_AHEAD, 8'h00, 7'd0, 5'd0);
        add_cmd(CMD_DEL_BEHIND, 8'h00, 7'd0, 5'd0);
        add_cmd(CMD_PUT, 8'h43, 7'd0, 5'd0);
        settle();

        write_attr(8'hFF);
        add_random(70);
        settle();

        send_idle_pct = 88;
        recv_idle_pct = 31;
        write_attr(8'h00);
        add_random(70);
        settle();

        // Back-to-back traffic, with a long receiver stall to fill the block
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_attr(8'($urandom_range(254, 1)));
        add_random(70);
        hold_asks = hold_asks + 1;
        settle();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tccw_pkg.sv
rtl/tccw_front.sv
rtl/tccw_opq.sv
rtl/tccw_back.sv
rtl/text_console_cursor_writer.sv
tb/sv/text_console_cursor_writer_tb.sv
